[hw/rtl/marp_pkg.sv]
package marp_pkg;

  // Fixed field widths.
  localparam int unsigned NoteW = 7;
  localparam int unsigned DurW  = 20;
  localparam int unsigned BlkW  = 14;
  localparam int unsigned OffW  = 13;
  localparam int unsigned TotW  = DurW + 1;

  localparam logic [DurW-1:0]  DurReset = 20'd6615;
  localparam logic [NoteW-1:0] VelOn    = 7'd127;
  localparam logic [NoteW-1:0] VelOff   = 7'd0;

  // Request codes on the input port.
  localparam logic [1:0] ReqNoteOn  = 2'd0;
  localparam logic [1:0] ReqNoteOff = 2'd1;
  localparam logic [1:0] ReqBlock   = 2'd2;

  // Event kinds on the result port.
  localparam logic EvtOff = 1'b0;
  localparam logic EvtOn  = 1'b1;

  // Queue depths, powers of two.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned EvtDepth = 4;

  typedef enum logic [1:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_BLOCK
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [NoteW-1:0] note;
    logic [BlkW-1:0]  blk;
  } cmd_t;

  typedef struct packed {
    logic             kind;
    logic [NoteW-1:0] note;
    logic [NoteW-1:0] vel;
    logic [OffW-1:0]  off;
    logic             last;
  } evt_t;

  typedef struct packed {
    logic            start;
    logic [TotW-1:0] dividend;
    logic [DurW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic            done;
    logic [DurW-1:0] rem;
  } rem_rsp_t;

endpackage

[hw/rtl/marp_front.sv]
module marp_front #(
  parameter int unsigned NOTE_RANGE = 128,
  parameter int unsigned MAX_BLOCK  = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [1:0]                  req_type_i,
  input  logic [marp_pkg::NoteW-1:0]  note_number_i,
  input  logic [marp_pkg::BlkW-1:0]   block_samples_i,
  output logic                        full_o,
  output marp_pkg::cmd_t              cmd_o,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i
);

  localparam int unsigned PtrW = $clog2(marp_pkg::CmdDepth);

  marp_pkg::cmd_t cls;
  logic           keep;
  logic           in_range;
  logic           wr_en;
  logic           rd_en;

  marp_pkg::cmd_t   q_mem [marp_pkg::CmdDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;

  assign in_range = 32'(note_number_i) < 32'(NOTE_RANGE);

  // Classify the item; unused codes and notes outside the range never enter the queue.
  always_comb begin
    keep      = 1'b0;
    cls.op    = marp_pkg::OP_BLOCK;
    cls.note  = note_number_i;
    cls.blk   = (32'(block_samples_i) > 32'(MAX_BLOCK)) ?
                marp_pkg::BlkW'(MAX_BLOCK) : block_samples_i;
    case (req_type_i)
      marp_pkg::ReqNoteOn: begin
        keep   = in_range;
        cls.op = marp_pkg::OP_NOTE_ON;
      end
      marp_pkg::ReqNoteOff: begin
        keep   = in_range;
        cls.op = marp_pkg::OP_NOTE_OFF;
      end
      marp_pkg::ReqBlock: begin
        keep   = 1'b1;
        cls.op = marp_pkg::OP_BLOCK;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o      = cnt_q == (PtrW+1)'(marp_pkg::CmdDepth);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign wr_en       = push_i && !full_o && keep;
  assign rd_en       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

[hw/rtl/marp_rem.sv]
module marp_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  marp_pkg::rem_req_t req_i,
  output marp_pkg::rem_rsp_t rsp_o
);

  localparam int unsigned TotW = marp_pkg::TotW;
  localparam int unsigned CntW = $clog2(TotW + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [TotW-1:0]            dvd_q, dvd_d;
  logic [TotW-1:0]            rem_q, rem_d;
  logic [marp_pkg::DurW-1:0]  dvs_q, dvs_d;
  logic [TotW-1:0]            shifted;
  logic [TotW-1:0]            trial;
  logic                       fits;

  // Restoring division, one dividend bit per cycle. The partial remainder stays
  // below the divisor, so its top bit is always clear before the shift.
  assign shifted = {rem_q[TotW-2:0], dvd_q[TotW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[TotW-2:0], 1'b0};
      rem_d = fits ? trial : shifted;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(TotW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[marp_pkg::DurW-1:0];

endmodule

[hw/rtl/marp_back.sv]
module marp_back #(
  parameter int unsigned NOTE_RANGE = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [marp_pkg::DurW-1:0]  dur_i,
  input  marp_pkg::cmd_t             cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  output marp_pkg::rem_req_t         rem_req_o,
  input  marp_pkg::rem_rsp_t         rem_rsp_i,
  output marp_pkg::evt_t             evt_o,
  output logic                       evt_push_o,
  input  logic                       evt_full_i
);

  localparam int unsigned NoteW = marp_pkg::NoteW;
  localparam int unsigned DurW  = marp_pkg::DurW;
  localparam int unsigned BlkW  = marp_pkg::BlkW;
  localparam int unsigned OffW  = marp_pkg::OffW;
  localparam int unsigned TotW  = marp_pkg::TotW;
  localparam int unsigned IdxW  = $clog2(NOTE_RANGE);
  localparam int unsigned CntW  = $clog2(NOTE_RANGE + 1);
  localparam int unsigned NGrp  = (NOTE_RANGE + 7) / 8;
  localparam int unsigned GrpW  = $clog2(NGrp);
  localparam int unsigned PadW  = NGrp * 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TGO   = 3'd1;
  localparam logic [2:0] S_TWAIT = 3'd2;
  localparam logic [2:0] S_EOFF  = 3'd3;
  localparam logic [2:0] S_SGO   = 3'd4;
  localparam logic [2:0] S_SWAIT = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_EON   = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [NOTE_RANGE-1:0] mask_q, mask_d;
  logic [CntW-1:0]       held_q, held_d;
  logic [IdxW-1:0]       step_q, step_d;
  logic [NoteW-1:0]      snd_note_q, snd_note_d;
  logic                  snd_q, snd_d;
  logic [DurW-1:0]       st_q, st_d;
  logic [DurW-1:0]       dur_q, dur_d;
  logic [BlkW-1:0]       blk_q, blk_d;
  logic [TotW-1:0]       tot_q, tot_d;
  logic                  bound_q, bound_d;
  logic [OffW-1:0]       off_q, off_d;
  logic [GrpW-1:0]       grp_q, grp_d;
  logic [CntW-1:0]       seen_q, seen_d;

  logic [DurW-1:0]       dur_eff;
  logic [TotW-1:0]       tot_new;
  logic [IdxW-1:0]       idx;
  logic [DurW-1:0]       diff;
  logic [DurW-1:0]       lim;
  logic [DurW-1:0]       off_full;
  logic [PadW-1:0]       pad;
  logic [7:0]            grp_bits;
  logic [3:0]            pop;
  logic [3:0]            run;
  logic [CntW-1:0]       rel;
  logic [2:0]            pos;
  logic                  hit;
  logic                  found;

  assign dur_eff = (dur_i == '0) ? DurW'(1) : dur_i;
  assign tot_new = TotW'(st_q) + TotW'(cmd_i.blk);
  assign idx     = cmd_i.note[IdxW-1:0];
  assign pad     = PadW'(mask_q);
  assign grp_bits = pad[8*grp_q +: 8];
  assign rel     = CntW'(step_q) - seen_q;

  // Offset of the step boundary inside the block, clamped to the block.
  always_comb begin
    diff     = dur_q - st_q;
    lim      = DurW'(blk_q) - DurW'(1);
    off_full = '0;
    if (dur_q > st_q && blk_q != '0) begin
      off_full = (diff > lim) ? lim : diff;
    end
  end

  // Rank search within one group of eight notes.
  always_comb begin
    pop = '0;
    run = '0;
    pos = '0;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (grp_bits[k]) begin
        if (!hit && run == rel[3:0]) begin
          pos = 3'(k);
          hit = 1'b1;
        end
        run = run + 4'd1;
      end
    end
    pop   = run;
    found = CntW'(pop) > rel;
  end

  assign cmd_ready_o = state_q == S_IDLE;

  always_comb begin
    evt_o.kind = (state_q == S_EON) ? marp_pkg::EvtOn : marp_pkg::EvtOff;
    evt_o.note = snd_note_q;
    evt_o.vel  = (state_q == S_EON) ? marp_pkg::VelOn : marp_pkg::VelOff;
    evt_o.off  = off_q;
    evt_o.last = (state_q == S_EON) || (held_q == '0);
  end

  always_comb begin
    state_d    = state_q;
    mask_d     = mask_q;
    held_d     = held_q;
    step_d     = step_q;
    snd_note_d = snd_note_q;
    snd_d      = snd_q;
    st_d       = st_q;
    dur_d      = dur_q;
    blk_d      = blk_q;
    tot_d      = tot_q;
    bound_d    = bound_q;
    off_d      = off_q;
    grp_d      = grp_q;
    seen_d     = seen_q;
    evt_push_o = 1'b0;
    rem_req_o.start    = 1'b0;
    rem_req_o.dividend = tot_q;
    rem_req_o.divisor  = dur_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            marp_pkg::OP_NOTE_ON: begin
              if (!mask_q[idx]) begin
                mask_d[idx] = 1'b1;
                held_d      = held_q + CntW'(1);
              end
            end
            marp_pkg::OP_NOTE_OFF: begin
              if (mask_q[idx]) begin
                mask_d[idx] = 1'b0;
                held_d      = held_q - CntW'(1);
              end
            end
            marp_pkg::OP_BLOCK: begin
              dur_d   = dur_eff;
              blk_d   = cmd_i.blk;
              tot_d   = tot_new;
              bound_d = tot_new >= {1'b0, dur_eff};
              state_d = S_TGO;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_TGO: begin
        rem_req_o.start = 1'b1;
        off_d   = off_full[OffW-1:0];
        state_d = S_TWAIT;
      end
      S_TWAIT: begin
        if (rem_rsp_i.done) begin
          st_d = rem_rsp_i.rem;
          if (!bound_q) begin
            state_d = S_IDLE;
          end else if (snd_q) begin
            state_d = S_EOFF;
          end else if (held_q != '0) begin
            state_d = S_SGO;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_EOFF: begin
        if (!evt_full_i) begin
          evt_push_o = 1'b1;
          snd_d      = 1'b0;
          state_d    = (held_q != '0) ? S_SGO : S_IDLE;
        end
      end
      S_SGO: begin
        rem_req_o.start    = 1'b1;
        rem_req_o.dividend = TotW'(step_q) + TotW'(1);
        rem_req_o.divisor  = DurW'(held_q);
        state_d = S_SWAIT;
      end
      S_SWAIT: begin
        if (rem_rsp_i.done) begin
          step_d  = rem_rsp_i.rem[IdxW-1:0];
          grp_d   = '0;
          seen_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (found && hit) begin
          snd_note_d = NoteW'({grp_q, pos});
          snd_d      = 1'b1;
          state_d    = S_EON;
        end else if (grp_q == GrpW'(NGrp - 1)) begin
          // Rank past the last held note cannot occur; fall back to note zero.
          snd_note_d = '0;
          snd_d      = 1'b1;
          state_d    = S_EON;
        end else begin
          seen_d = seen_q + CntW'(pop);
          grp_d  = grp_q + GrpW'(1);
        end
      end
      S_EON: begin
        if (!evt_full_i) begin
          evt_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mask_q     <= '0;
      held_q     <= '0;
      step_q     <= '0;
      snd_note_q <= '0;
      snd_q      <= 1'b0;
      st_q       <= '0;
    end else begin
      state_q    <= state_d;
      mask_q     <= mask_d;
      held_q     <= held_d;
      step_q     <= step_d;
      snd_note_q <= snd_note_d;
      snd_q      <= snd_d;
      st_q       <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dur_q   <= dur_d;
    blk_q   <= blk_d;
    tot_q   <= tot_d;
    bound_q <= bound_d;
    off_q   <= off_d;
    grp_q   <= grp_d;
    seen_q  <= seen_d;
  end

endmodule

[hw/rtl/marp_outq.sv]
module marp_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  marp_pkg::evt_t evt_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output marp_pkg::evt_t evt_o
);

  localparam int unsigned PtrW = $clog2(marp_pkg::EvtDepth);

  marp_pkg::evt_t  q_mem [marp_pkg::EvtDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            wr_en;
  logic            rd_en;

  assign full_o  = cnt_q == (PtrW+1)'(marp_pkg::EvtDepth);
  assign empty_o = cnt_q == '0;
  assign evt_o   = q_mem[rd_ptr_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + (PtrW+1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= evt_i;
    end
  end

endmodule

[hw/rtl/midi_arpeggiator_step.sv]
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+----------------------------------------
// request   | push / full, taken on push & !full | req_type_i, note_number_i, block_samples_i
// event     | empty / pop, taken on pop & !empty | event_kind_o, out_note_o, velocity_o,
//           |                                   | sample_offset_o, last_of_run_o
// config    | cfg_valid_i / cfg_ready_o          | note_duration_i
//
// Note-on and note-off items update the held-note mask while the sequencer stays idle. A block
// item runs the remainder unit once to advance the timer and, at a step boundary with notes
// held, a second time to pick the step, then a rank search of eight notes per cycle.
// Four-entry queues on both sides let input and output stall independently.
// Reset clears the held-note mask, counters and timer at once; no clearing pass.
module midi_arpeggiator_step #(
  parameter int unsigned NOTE_RANGE = 128,
  parameter int unsigned MAX_BLOCK  = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [1:0]                  req_type_i,
  input  logic [marp_pkg::NoteW-1:0]  note_number_i,
  input  logic [marp_pkg::BlkW-1:0]   block_samples_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        event_kind_o,
  output logic [marp_pkg::NoteW-1:0]  out_note_o,
  output logic [marp_pkg::NoteW-1:0]  velocity_o,
  output logic [marp_pkg::OffW-1:0]   sample_offset_o,
  output logic                        last_of_run_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [marp_pkg::DurW-1:0]   note_duration_i
);

  logic [marp_pkg::DurW-1:0] dur_q, dur_d;
  marp_pkg::cmd_t     cmd;
  logic               cmd_valid;
  logic               cmd_ready;
  marp_pkg::rem_req_t rem_req;
  marp_pkg::rem_rsp_t rem_rsp;
  marp_pkg::evt_t     evt_in;
  marp_pkg::evt_t     evt_out;
  logic               evt_push;
  logic               evt_full;

  assign cfg_ready_o = 1'b1;
  assign dur_d       = (cfg_valid_i && cfg_ready_o) ? note_duration_i : dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= marp_pkg::DurReset;
    end else begin
      dur_q <= dur_d;
    end
  end

  marp_front #(
    .NOTE_RANGE(NOTE_RANGE),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .req_type_i     (req_type_i),
    .note_number_i  (note_number_i),
    .block_samples_i(block_samples_i),
    .full_o         (full),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready)
  );

  marp_rem u_rem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rem_req),
    .rsp_o (rem_rsp)
  );

  marp_back #(
    .NOTE_RANGE(NOTE_RANGE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dur_i      (dur_q),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .rem_req_o  (rem_req),
    .rem_rsp_i  (rem_rsp),
    .evt_o      (evt_in),
    .evt_push_o (evt_push),
    .evt_full_i (evt_full)
  );

  marp_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (evt_push),
    .evt_i  (evt_in),
    .full_o (evt_full),
    .pop_i  (pop),
    .empty_o(empty),
    .evt_o  (evt_out)
  );

  assign event_kind_o    = evt_out.kind;
  assign out_note_o      = evt_out.note;
  assign velocity_o      = evt_out.vel;
  assign sample_offset_o = evt_out.off;
  assign last_of_run_o   = evt_out.last;

endmodule

[hw/rtl/marp_checker.sv]
module marp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic                        event_kind_o,
  input logic [marp_pkg::NoteW-1:0]  out_note_o,
  input logic [marp_pkg::NoteW-1:0]  velocity_o,
  input logic [marp_pkg::OffW-1:0]   sample_offset_o,
  input logic                        last_of_run_o
);

  // A note-on always closes the run of events for its block.
  a_on_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && event_kind_o == marp_pkg::EvtOn |-> last_of_run_o)
    else $error("note-on item not marked as last of run");

  // Velocity follows the event kind.
  a_on_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && event_kind_o == marp_pkg::EvtOn |-> velocity_o == marp_pkg::VelOn)
    else $error("note-on item with wrong velocity");

  a_off_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && event_kind_o == marp_pkg::EvtOff |-> velocity_o == marp_pkg::VelOff)
    else $error("note-off item with nonzero velocity");

  // A waiting item that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_note_o) && $stable(sample_offset_o)
      && $stable(event_kind_o) && $stable(last_of_run_o))
    else $error("waiting item changed before it was taken");

endmodule

bind midi_arpeggiator_step marp_checker u_marp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .event_kind_o   (event_kind_o),
  .out_note_o     (out_note_o),
  .velocity_o     (velocity_o),
  .sample_offset_o(sample_offset_o),
  .last_of_run_o  (last_of_run_o)
);
